// File: rtl/sky_gradient_ray_shader_unit_assert.svh
// ---------------------------------------------------------------------------
// Sky gradient shader assertion macros
// Shared concurrent assertion forms for the shader RTL.
// ---------------------------------------------------------------------------
`ifndef SKY_GRADIENT_RAY_SHADER_UNIT_ASSERT_SVH
`define SKY_GRADIENT_RAY_SHADER_UNIT_ASSERT_SVH

// same-cycle implication
`define SGRS_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SGRS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sgrs_pkg.sv
// ---------------------------------------------------------------------------
// Sky gradient shader package
// Field widths, register codes and color constants.
// ---------------------------------------------------------------------------
package sgrs_pkg;

    localparam int COORD_W   = 12;
    localparam int VP_W      = 16;
    localparam int DIM_W     = 13;
    localparam int CH_W      = 8;
    localparam int FRAC_W    = 12;
    localparam int NY_FRAC_W = 15;
    localparam int DIR_W     = 27;
    localparam int DZ_W      = 28;
    localparam int ROOT_W    = 29;
    localparam int MAG_W     = 16;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VP_WIDTH  = 3'd0,
        REG_VP_HEIGHT = 3'd1,
        REG_FOCAL     = 3'd2,
        REG_IMG_WIDTH = 3'd3,
        REG_IMG_HEIGHT = 3'd4
    } cfg_idx_t;

    localparam logic [VP_W-1:0]  RST_VP_WIDTH   = 16'd8192;
    localparam logic [VP_W-1:0]  RST_VP_HEIGHT  = 16'd8192;
    localparam logic [VP_W-1:0]  RST_FOCAL      = 16'd4096;
    localparam logic [DIM_W-1:0] RST_IMG_WIDTH  = 13'd256;
    localparam logic [DIM_W-1:0] RST_IMG_HEIGHT = 13'd256;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

endpackage

// File: rtl/sgrs_div.sv
// ---------------------------------------------------------------------------
// Sky gradient shader pipelined divider
// Restoring divider, one quotient bit per stage, side data carried along.
// ---------------------------------------------------------------------------
module sgrs_div #(
    parameter int NW = 40,
    parameter int DW = 13,
    parameter int QW = 27,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic          vld_reg  [QW];
    logic [CW-1:0] rem_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic          vld_in;
        logic [CW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [SW-1:0] side_in_k;
        logic [CW-1:0] trial;
        logic          ge;
        logic [CW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (k == 0) begin : g_first
            assign vld_in    = in_valid;
            assign rem_in    = CW'(num);
            assign den_in    = den;
            assign quo_in    = '0;
            assign side_in_k = side_in;
        end
        else begin : g_rest
            assign vld_in    = vld_reg[k-1];
            assign rem_in    = rem_reg[k-1];
            assign den_in    = den_reg[k-1];
            assign quo_in    = quo_reg[k-1];
            assign side_in_k = side_reg[k-1];
        end

        assign trial = CW'(den_in) << B;
        assign ge    = rem_in >= trial;

        always_comb
        begin
            rem_next    = ge ? rem_in - trial : rem_in;
            quo_next    = quo_in;
            quo_next[B] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            den_reg[k]  <= den_in;
            quo_reg[k]  <= quo_next;
            side_reg[k] <= side_in_k;
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign side_out  = side_reg[QW-1];

`include "sky_gradient_ray_shader_unit_assert.svh"

    `SGRS_ASSERT_IMPL(a_rem_below_den, clk, rst_n, vld_reg[QW-1], rem_reg[QW-1] < CW'(den_reg[QW-1]), "divider remainder not below divisor")

endmodule

// File: rtl/sgrs_sqrt.sv
// ---------------------------------------------------------------------------
// Sky gradient shader pipelined square root
// Digit-by-digit integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
module sgrs_sqrt #(
    parameter int RW = 29,
    parameter int SW = 28
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [2*RW-1:0] radicand,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [RW-1:0]   root,
    output logic [SW-1:0]   side_out
);

    localparam int TW = 2 * RW + 1;

    logic          vld_reg  [RW];
    logic [TW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [SW-1:0] side_reg [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int J = RW - 1 - k;
        logic          vld_in;
        logic [TW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [SW-1:0] side_in_k;
        logic [TW-1:0] trial;
        logic          ge;
        logic [TW-1:0] rem_next;
        logic [RW-1:0] root_next;

        if (k == 0) begin : g_first
            assign vld_in    = in_valid;
            assign rem_in    = TW'(radicand);
            assign root_in   = '0;
            assign side_in_k = side_in;
        end
        else begin : g_rest
            assign vld_in    = vld_reg[k-1];
            assign rem_in    = rem_reg[k-1];
            assign root_in   = root_reg[k-1];
            assign side_in_k = side_reg[k-1];
        end

        // (root + 2^J)^2 - root^2 = root*2^(J+1) + 2^(2J)
        assign trial = (TW'(root_in) << (J + 1)) + (TW'(1) << (2 * J));
        assign ge    = rem_in >= trial;

        always_comb
        begin
            rem_next     = ge ? rem_in - trial : rem_in;
            root_next    = root_in;
            root_next[J] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            side_reg[k] <= side_in_k;
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

// File: rtl/sgrs_color.sv
// ---------------------------------------------------------------------------
// Sky gradient shader color stage
// Maps the normalized ray y to the blend factor and the 8-bit channels.
// ---------------------------------------------------------------------------
module sgrs_color (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [sgrs_pkg::MAG_W-1:0] mag,
    input  logic                       neg,
    output logic                       done,
    output logic [sgrs_pkg::CH_W-1:0]  red,
    output logic [sgrs_pkg::CH_W-1:0]  green,
    output logic [sgrs_pkg::CH_W-1:0]  blue
);

    import sgrs_pkg::*;

    localparam logic [17:0] SCALE_K   = 18'd255999;
    localparam logic [16:0] HALF      = 17'd32768;
    localparam logic [16:0] POS_MAX   = 17'd32767;
    localparam logic [17:0] RED_ONE   = 18'd131072;
    localparam logic [19:0] GRN_ONE   = 20'd655360;
    // reciprocals of 1000 and 5000, exact over the reachable range
    localparam logic [18:0] RED_RECIP = 19'd268436;
    localparam int          RED_SHIFT = 28;
    localparam logic [19:0] GRN_RECIP = 20'd858994;
    localparam int          GRN_SHIFT = 32;

    logic [16:0] mag_pos;
    logic [15:0] t;
    logic [17:0] v_r;
    logic [19:0] v_g;
    logic [35:0] prod_r_next;
    logic [37:0] prod_g_next;

    logic        va_reg;
    logic [35:0] prod_r_reg;
    logic [37:0] prod_g_reg;

    logic [17:0] y_r;
    logic [20:0] y_g;
    logic [36:0] red_prod;
    logic [40:0] grn_prod;

    logic [CH_W-1:0] red_next;
    logic [CH_W-1:0] green_next;
    logic            done_reg;
    logic [CH_W-1:0] red_reg;
    logic [CH_W-1:0] green_reg;

    always_comb
    begin
        mag_pos = (17'(mag) > POS_MAX) ? POS_MAX : 17'(mag);
        if (neg)
        begin
            t = 16'(HALF - 17'(mag));
        end
        else
        begin
            t = 16'(HALF + mag_pos);
        end
        v_r         = RED_ONE - 18'(t);
        v_g         = GRN_ONE - 20'(t) * 20'd3;
        prod_r_next = 36'(v_r) * 36'(SCALE_K);
        prod_g_next = 38'(v_g) * 38'(SCALE_K);
    end

    always_comb
    begin
        y_r        = 18'(prod_r_reg >> 17);
        y_g        = 21'(prod_g_reg >> 17);
        red_prod   = 37'(y_r) * 37'(RED_RECIP);
        grn_prod   = 41'(y_g) * 41'(GRN_RECIP);
        red_next   = CH_W'(red_prod >> RED_SHIFT);
        green_next = CH_W'(grn_prod >> GRN_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= in_valid;
            done_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_r_reg <= prod_r_next;
        prod_g_reg <= prod_g_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = CH_MAX;

`include "sky_gradient_ray_shader_unit_assert.svh"

    `SGRS_ASSERT_IMPL(a_red_le_green, clk, rst_n, done_reg, red_reg <= green_reg, "red above green")
    `SGRS_ASSERT_IMPL(a_ch_floor, clk, rst_n, done_reg, (red_reg >= 8'd127) && (green_reg >= 8'd179), "channel below gradient floor")
    `SGRS_ASSERT_NEXT(a_stage_flow, clk, rst_n, va_reg, done_reg, "color stage lost a word")

endmodule

// File: rtl/sky_gradient_ray_shader_unit.sv
// ---------------------------------------------------------------------------
// Sky gradient ray shader
// Builds the camera ray for a pixel, normalizes it and blends the sky color.
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// pixel     in         start & !busy        pixel_x, pixel_y
// color     out        done (one cycle)     red, green, blue
// config    in         cfg_wr               cfg_addr, cfg_data
//
// One pixel per clock; busy is never raised.
// Path: entry register, lateral divide, square, sum, square root,
// normalize divide, color stage.
// Reset clears valid bits and loads the register defaults.
// Results cannot be held off; each word shows on done for one cycle.
// ---------------------------------------------------------------------------
module sky_gradient_ray_shader_unit #(
    parameter int MAX_DIM = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [sgrs_pkg::COORD_W-1:0]   pixel_x,
    input  logic [sgrs_pkg::COORD_W-1:0]   pixel_y,
    input  logic                           cfg_wr,
    input  logic [sgrs_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [sgrs_pkg::VP_W-1:0]      cfg_data,
    output logic                           done,
    output logic [sgrs_pkg::CH_W-1:0]      red,
    output logic [sgrs_pkg::CH_W-1:0]      green,
    output logic [sgrs_pkg::CH_W-1:0]      blue
);

    import sgrs_pkg::*;

    localparam int SPAN_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
    localparam int EXT_W  = (SPAN_W + 2 > DIM_W + 1) ? SPAN_W + 2 : DIM_W + 1;
    localparam int PROD_W = VP_W + SPAN_W;
    localparam int NUM_W  = PROD_W + FRAC_W;
    localparam int DEN_W  = SPAN_W + 1;
    localparam int SUM_W  = 2 * ROOT_W;
    localparam int MNUM_W = DIR_W + NY_FRAC_W;

    typedef struct packed {
        logic              neg;
        logic [SPAN_W-1:0] m;
        logic [SPAN_W-1:0] span;
    } lat_t;

    logic [VP_W-1:0]  vp_w_reg;
    logic [VP_W-1:0]  vp_h_reg;
    logic [VP_W-1:0]  focal_reg;
    logic [DIM_W-1:0] img_w_reg;
    logic [DIM_W-1:0] img_h_reg;

    lat_t xl;
    lat_t yl;

    logic              v0_reg;
    logic [PROD_W-1:0] px_reg;
    logic [PROD_W-1:0] py_reg;
    logic [DEN_W-1:0]  dnx_reg;
    logic [DEN_W-1:0]  dny_reg;
    logic              ny_neg_reg;
    logic [VP_W-1:0]   foc0_reg;

    logic             dvx_valid;
    logic             dvy_valid;
    logic [DIR_W-1:0] dx_q;
    logic [DIR_W-1:0] dy_q;
    logic             dx_neg;
    logic [VP_W-1:0]  dy_foc;
    logic [DZ_W-1:0]  dz;

    logic               vsq_reg;
    logic [2*DIR_W-1:0] dx2_reg;
    logic [2*DIR_W-1:0] dy2_reg;
    logic [2*DZ_W-1:0]  dz2_reg;
    logic [DIR_W-1:0]   dy_sq_reg;
    logic               neg_sq_reg;

    logic             vsum_reg;
    logic [SUM_W-1:0] s_reg;
    logic [DIR_W-1:0] dy_sum_reg;
    logic             neg_sum_reg;

    logic              rt_valid;
    logic [ROOT_W-1:0] rt;
    logic [DIR_W:0]    rt_side;
    logic [ROOT_W-1:0] rt_den;

    logic             mag_valid;
    logic [MAG_W-1:0] mag_q;
    logic             mag_neg;

    function automatic lat_t lateral(logic [DIM_W-1:0] dim, logic [COORD_W-1:0] coord);
        logic [EXT_W-1:0] e;
        logic [EXT_W-1:0] span;
        logic [EXT_W-1:0] c;
        logic [EXT_W-1:0] twice;
        lat_t             r;
        e = EXT_W'(dim);
        if (e > EXT_W'(MAX_DIM))
        begin
            e = EXT_W'(MAX_DIM);
        end
        if (e < EXT_W'(2))
        begin
            e = EXT_W'(2);
        end
        span = e - EXT_W'(1);
        c    = EXT_W'(coord);
        if (c > span)
        begin
            c = span;
        end
        twice  = c << 1;
        r.neg  = twice < span;
        r.m    = r.neg ? SPAN_W'(span - twice) : SPAN_W'(twice - span);
        r.span = SPAN_W'(span);
        return r;
    endfunction

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_w_reg  <= RST_VP_WIDTH;
            vp_h_reg  <= RST_VP_HEIGHT;
            focal_reg <= RST_FOCAL;
            img_w_reg <= RST_IMG_WIDTH;
            img_h_reg <= RST_IMG_HEIGHT;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_VP_WIDTH:   vp_w_reg  <= cfg_data;
                REG_VP_HEIGHT:  vp_h_reg  <= cfg_data;
                REG_FOCAL:      focal_reg <= cfg_data;
                REG_IMG_WIDTH:  img_w_reg <= cfg_data[DIM_W-1:0];
                REG_IMG_HEIGHT: img_h_reg <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // entry: clamp, fold about the center, scale by viewport size
    always_comb
    begin
        xl = lateral(img_w_reg, pixel_x);
        yl = lateral(img_h_reg, pixel_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            vsq_reg  <= 1'b0;
            vsum_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= start & ~busy;
            vsq_reg  <= dvx_valid & dvy_valid;
            vsum_reg <= vsq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= PROD_W'(vp_w_reg) * PROD_W'(xl.m);
        py_reg     <= PROD_W'(vp_h_reg) * PROD_W'(yl.m);
        dnx_reg    <= {xl.span, 1'b0};
        dny_reg    <= {yl.span, 1'b0};
        ny_neg_reg <= yl.neg;
        foc0_reg   <= focal_reg;
    end

    sgrs_div #(
        .NW (NUM_W),
        .DW (DEN_W),
        .QW (DIR_W),
        .SW (1)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .num       ({px_reg, {FRAC_W{1'b0}}}),
        .den       (dnx_reg),
        .side_in   (ny_neg_reg),
        .out_valid (dvx_valid),
        .quo       (dx_q),
        .side_out  (dx_neg)
    );

    sgrs_div #(
        .NW (NUM_W),
        .DW (DEN_W),
        .QW (DIR_W),
        .SW (VP_W)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .num       ({py_reg, {FRAC_W{1'b0}}}),
        .den       (dny_reg),
        .side_in   (foc0_reg),
        .out_valid (dvy_valid),
        .quo       (dy_q),
        .side_out  (dy_foc)
    );

    assign dz = {dy_foc, {FRAC_W{1'b0}}};

    always_ff @(posedge clk)
    begin
        dx2_reg     <= (2*DIR_W)'(dx_q) * (2*DIR_W)'(dx_q);
        dy2_reg     <= (2*DIR_W)'(dy_q) * (2*DIR_W)'(dy_q);
        dz2_reg     <= (2*DZ_W)'(dz) * (2*DZ_W)'(dz);
        dy_sq_reg   <= dy_q;
        neg_sq_reg  <= dx_neg;
        s_reg       <= SUM_W'(dx2_reg) + SUM_W'(dy2_reg) + SUM_W'(dz2_reg);
        dy_sum_reg  <= dy_sq_reg;
        neg_sum_reg <= neg_sq_reg;
    end

    sgrs_sqrt #(
        .RW (ROOT_W),
        .SW (DIR_W + 1)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vsum_reg),
        .radicand  (s_reg),
        .side_in   ({neg_sum_reg, dy_sum_reg}),
        .out_valid (rt_valid),
        .root      (rt),
        .side_out  (rt_side)
    );

    // zero-length ray: numerator is zero too, quotient comes out zero
    assign rt_den = (rt == '0) ? ROOT_W'(1) : rt;

    sgrs_div #(
        .NW (MNUM_W),
        .DW (ROOT_W),
        .QW (MAG_W),
        .SW (1)
    ) u_div_n (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .num       ({rt_side[DIR_W-1:0], {NY_FRAC_W{1'b0}}}),
        .den       (rt_den),
        .side_in   (rt_side[DIR_W]),
        .out_valid (mag_valid),
        .quo       (mag_q),
        .side_out  (mag_neg)
    );

    sgrs_color u_color (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mag_valid),
        .mag      (mag_q),
        .neg      (mag_neg),
        .done     (done),
        .red      (red),
        .green    (green),
        .blue     (blue)
    );

`include "sky_gradient_ray_shader_unit_assert.svh"

    `SGRS_ASSERT_IMPL(a_mag_unit, clk, rst_n, mag_valid, mag_q <= 16'd32768, "normalized y above one")

endmodule

// File: tb/sv/sky_gradient_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sky gradient shader checker
// Watches the pixel, color and config channels, predicts each color word
// from its own copy of the registers and compares it with the next word out.
// ---------------------------------------------------------------------------
module sky_gradient_checker #(
    parameter int MAX_DIM = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [sgrs_pkg::COORD_W-1:0]   pixel_x,
    input  logic [sgrs_pkg::COORD_W-1:0]   pixel_y,
    input  logic                           cfg_wr,
    input  logic [sgrs_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [sgrs_pkg::VP_W-1:0]      cfg_data,
    input  logic                           done,
    input  logic [sgrs_pkg::CH_W-1:0]      red,
    input  logic [sgrs_pkg::CH_W-1:0]      green,
    input  logic [sgrs_pkg::CH_W-1:0]      blue,
    output int                             mismatches,
    output int                             pending,
    output int                             colors_seen
);

    import sgrs_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } color_t;

    logic [VP_W-1:0]  vp_width;
    logic [VP_W-1:0]  vp_height;
    logic [VP_W-1:0]  focal;
    logic [DIM_W-1:0] img_width;
    logic [DIM_W-1:0] img_height;
    color_t           colors_due[$];

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_w;
        res   = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (v >= res + bit_w)
            begin
                v   = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end
            else
                res = res >> 1;
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] ray_side(input logic [15:0] size_q12,
                                             input logic [12:0] dim,
                                             input logic [11:0] coord_in,
                                             output logic neg);
        logic [63:0] e;
        logic [63:0] span;
        logic [63:0] coord;
        logic [63:0] m;
        e = dim;
        if (e > MAX_DIM)
            e = MAX_DIM;
        if (e < 2)
            e = 2;
        span  = e - 1;
        coord = coord_in;
        if (coord > span)
            coord = span;
        if (coord * 2 >= span)
        begin
            m   = coord * 2 - span;
            neg = 1'b0;
        end
        else
        begin
            m   = span - coord * 2;
            neg = 1'b1;
        end
        return ((64'(size_q12) * m) << 12) / (2 * span);
    endfunction

    function automatic color_t sky_color(input logic [11:0] x, input logic [11:0] y);
        logic        x_neg;
        logic        y_neg;
        logic [63:0] dx;
        logic [63:0] dy;
        logic [63:0] dz;
        logic [63:0] root;
        logic [63:0] mag;
        logic [63:0] t;
        logic [63:0] rv;
        logic [63:0] gv;
        color_t      c;
        dx   = ray_side(vp_width, img_width, x, x_neg);
        dy   = ray_side(vp_height, img_height, y, y_neg);
        dz   = 64'(focal) << 12;
        root = root_floor(dx * dx + dy * dy + dz * dz);
        mag  = (root != 0) ? (dy << 15) / root : 64'd0;
        if (mag > 32768)
            mag = 32768;
        if (y_neg)
            t = 32768 - mag;
        else
        begin
            if (mag > 32767)
                mag = 32767;
            t = 32768 + mag;
        end
        rv = (64'd255999 * (64'd131072 - t)) / 64'd131072000;
        gv = (64'd255999 * (64'd655360 - 3 * t)) / 64'd655360000;
        c.r = (rv > 255) ? CH_MAX : rv[7:0];
        c.g = (gv > 255) ? CH_MAX : gv[7:0];
        c.b = CH_MAX;
        return c;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        color_t exp_c;
        if (!rst_n)
        begin
            vp_width    <= RST_VP_WIDTH;
            vp_height   <= RST_VP_HEIGHT;
            focal       <= RST_FOCAL;
            img_width   <= RST_IMG_WIDTH;
            img_height  <= RST_IMG_HEIGHT;
            mismatches  <= 0;
            colors_seen <= 0;
            colors_due.delete();
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_addr)
                    REG_VP_WIDTH:   vp_width   <= cfg_data;
                    REG_VP_HEIGHT:  vp_height  <= cfg_data;
                    REG_FOCAL:      focal      <= cfg_data;
                    REG_IMG_WIDTH:  img_width  <= cfg_data[DIM_W-1:0];
                    REG_IMG_HEIGHT: img_height <= cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (done)
            begin
                colors_seen <= colors_seen + 1;
                if (colors_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("color word with nothing due: r=%0d g=%0d b=%0d",
                                 red, green, blue);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_c = colors_due.pop_front();
                    if (red !== exp_c.r || green !== exp_c.g || blue !== exp_c.b)
                    begin
                        if (mismatches < 10)
                            $display("color mismatch: exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                     exp_c.r, exp_c.g, exp_c.b, red, green, blue);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (start && !busy)
                colors_due.push_back(sky_color(pixel_x, pixel_y));
        end
    end

    assign pending = colors_due.size();

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sky gradient shader testbench
// Drives pixels under a series of viewport and image settings with varied
// sender gaps; the checker predicts every color word and counts mismatches.
// ---------------------------------------------------------------------------
module testbench;
    import sgrs_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [COORD_W-1:0]   pixel_x = '0;
    logic [COORD_W-1:0]   pixel_y = '0;
    logic                 cfg_wr = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = REG_VP_WIDTH;
    logic [VP_W-1:0]      cfg_data = '0;
    logic                 done;
    logic [CH_W-1:0]      red;
    logic [CH_W-1:0]      green;
    logic [CH_W-1:0]      blue;
    int                   mismatches;
    int                   pending;
    int                   colors_seen;
    int                   idle_pct = 0;
    int                   quiet_cycles = 0;
    int                   pixels_sent = 0;
    int                   settings_run = 0;
    int                   cur_w = 256;
    int                   cur_h = 256;

    always #1 clk = ~clk;

    sky_gradient_ray_shader_unit u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pixel_x(pixel_x), .pixel_y(pixel_y),
        .cfg_wr(cfg_wr), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .done(done), .red(red), .green(green), .blue(blue)
    );

    sky_gradient_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pixel_x(pixel_x), .pixel_y(pixel_y),
        .cfg_wr(cfg_wr), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .done(done), .red(red), .green(green), .blue(blue),
        .mismatches(mismatches), .pending(pending), .colors_seen(colors_seen)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_wr || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000)
        begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [VP_W-1:0] val);
        cfg_wr   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr <= 1'b0;
    endtask

    task automatic apply_view(input int vw, input int vh, input int f,
                              input int iw, input int ih);
        write_reg(REG_VP_WIDTH, vw[15:0]);
        write_reg(REG_VP_HEIGHT, vh[15:0]);
        write_reg(REG_FOCAL, f[15:0]);
        write_reg(REG_IMG_WIDTH, iw[15:0]);
        write_reg(REG_IMG_HEIGHT, ih[15:0]);
        // unmapped index must be ignored
        cfg_wr   <= 1'b1;
        cfg_addr <= CFG_IDX_W'($urandom_range(5, 7));
        cfg_data <= VP_W'($urandom);
        @(posedge clk);
        cfg_wr <= 1'b0;
        cur_w = (iw < 2) ? 2 : (iw > 4096 ? 4096 : iw);
        cur_h = (ih < 2) ? 2 : (ih > 4096 ? 4096 : ih);
        settings_run++;
    endtask

    task automatic shade(input int x, input int y);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        pixel_x <= x[11:0];
        pixel_y <= y[11:0];
        do
            @(posedge clk);
        while (busy);
        pixels_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic random_pixels(input int n);
        int x;
        int y;
        for (int i = 0; i < n; i++)
        begin
            x = ($urandom_range(3) != 0) ? $urandom_range(cur_w - 1) : $urandom_range(4095);
            y = ($urandom_range(3) != 0) ? $urandom_range(cur_h - 1) : $urandom_range(4095);
            shade(x, y);
            if (i == n / 2 && $urandom_range(1))
                drain();
        end
    endtask

    initial
    begin
        int modes[4] = '{0, 68, 0, 27};
        int dims[4]  = '{2, 3, 4096, 8191};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset view: corners, center, beyond the image
        shade(0, 0);
        shade(255, 255);
        shade(0, 255);
        shade(255, 0);
        shade(127, 128);
        shade(4095, 4095);
        shade(4095, 0);
        shade(300, 2048);
        drain();

        // zero focal with odd sizes: straight up and a zero-length ray
        apply_view(8192, 8192, 0, 3, 3);
        shade(1, 2);
        shade(1, 0);
        shade(0, 1);
        shade(1, 1);
        drain();
        apply_view(0, 0, 0, 5, 5);
        shade(2, 2);
        shade(4095, 0);
        drain();

        // size clamps and register extremes
        apply_view(65535, 65535, 1, 0, 1);
        shade(0, 0);
        shade(1, 1);
        shade(4095, 2048);
        drain();
        apply_view(1, 1, 65535, 8191, 8191);
        shade(0, 0);
        shade(4095, 4095);
        shade(2048, 2047);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            idle_pct = modes[p % 4];
            case (p)
                0: apply_view(8192, 8192, 4096, 256, 256);
                1: apply_view(65535, 1, 1, 2, 4096);
                2: apply_view(1, 65535, 65535, 4096, 2);
                default:
                    apply_view($urandom_range(1, 65535), $urandom_range(1, 65535),
                               ($urandom_range(3) == 0) ? $urandom_range(0, 64)
                                                        : $urandom_range(1, 65535),
                               ($urandom_range(3) == 0) ? dims[$urandom_range(3)]
                                                        : $urandom_range(2, 300),
                               ($urandom_range(3) == 0) ? dims[$urandom_range(3)]
                                                        : $urandom_range(2, 300));
            endcase
            random_pixels(165);
            drain();
        end

        $display("%0d pixels over %0d view settings, %0d color words checked",
                 pixels_sent, settings_run + 1, colors_seen);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/sgrs_pkg.sv
rtl/sgrs_div.sv
rtl/sgrs_sqrt.sv
rtl/sgrs_color.sv
rtl/sky_gradient_ray_shader_unit.sv
tb/sv/sky_gradient_checker.sv
tb/sv/testbench.sv
